// ----- rtl/dupf_pkg.sv -----
// Shared constants and types for the duplicate entry pair finder.
// No dependencies.
package dupf_pkg;

  localparam int CS_W            = 32;
  localparam int SZ_W            = 64;
  localparam int IDX_W           = 6;
  localparam int ENTRY_W         = CS_W + SZ_W;
  localparam int DEF_MAX_ENTRIES = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

endpackage

// ----- rtl/dupf_entry_mem.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on dupf_pkg for the entry width.
module dupf_entry_mem
  import dupf_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int ADDR_W      = $clog2(MAX_ENTRIES)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/duplicate_entry_pair_finder.sv -----
// Top level: sequencer that stores entries and scans the table for duplicates.
// Depends on dupf_pkg and dupf_entry_mem.
//
//  channel   handshake              payload
//  --------  ---------------------  ----------------------------------------------
//  item in   start & !busy          kind, checksum, entry_size
//  result    result_valid (1 cyc)   pair_valid, earlier_index, new_index,
//                                   table_full, last
//
// An add into a table holding k entries (k > 0) runs through acceptance in
// ST_IDLE, k reads of the entry memory in ST_SCAN, the compare of the last
// read in ST_FLUSH and the final result formed in ST_FINISH, which is on the
// ports in the cycle after. Clear, an add into an empty table and an add into
// a full table end in the accepting cycle. Results are sent one per cycle; the
// receiver cannot stall. Reset empties the table; memory is not cleared.
module duplicate_entry_pair_finder
  import dupf_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             kind,
  input  logic [CS_W-1:0]  checksum,
  input  logic [SZ_W-1:0]  entry_size,
  output logic             result_valid,
  output logic             pair_valid,
  output logic [IDX_W-1:0] earlier_index,
  output logic [IDX_W-1:0] new_index,
  output logic             table_full,
  output logic             last
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = ADDR_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  state_t state, state_next;

  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  pos;
  logic [ADDR_W-1:0]  rd_idx;
  logic [ADDR_W-1:0]  rd_tag;
  logic               rd_vld;
  logic [ADDR_W-1:0]  held_idx;
  logic               held_vld;
  logic [CS_W-1:0]    key_cs;
  logic [SZ_W-1:0]    key_sz;
  logic [ENTRY_W-1:0] rd_data;

  logic accept, is_clear, is_full, wr_en, rd_en, hit, scan_end;

  assign accept   = start && !busy;
  assign is_clear = (kind_t'(kind) == KIND_CLEAR);
  assign is_full  = (count == CNT_MAX);
  assign wr_en    = accept && !is_clear && !is_full;
  assign hit      = rd_vld && (rd_data == {key_cs, key_sz});
  assign scan_end = (rd_idx == pos - ADDR_W'(1));

  dupf_entry_mem #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({checksum, entry_size}),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (wr_en && count != '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != ST_IDLE);
    rd_en = (state == ST_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rd_vld       <= 1'b0;
      held_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_vld       <= rd_en;
      rd_tag       <= rd_idx;

      if (accept) begin
        if (is_clear) begin
          count <= '0;
        end else if (is_full) begin
          result_valid  <= 1'b1;
          pair_valid    <= 1'b0;
          earlier_index <= '0;
          new_index     <= '0;
          table_full    <= 1'b1;
          last          <= 1'b1;
        end else begin
          key_cs   <= checksum;
          key_sz   <= entry_size;
          pos      <= count[ADDR_W-1:0];
          count    <= count + CNT_W'(1);
          rd_idx   <= '0;
          held_vld <= 1'b0;
          if (count == '0) begin
            result_valid  <= 1'b1;
            pair_valid    <= 1'b0;
            earlier_index <= '0;
            new_index     <= '0;
            table_full    <= 1'b0;
            last          <= 1'b1;
          end
        end
      end

      if (state == ST_SCAN) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end

      // hold back one match so the final pair can carry last
      if (hit) begin
        held_idx <= rd_tag;
        held_vld <= 1'b1;
        if (held_vld) begin
          result_valid  <= 1'b1;
          pair_valid    <= 1'b1;
          earlier_index <= IDX_W'(held_idx);
          new_index     <= IDX_W'(pos);
          table_full    <= 1'b0;
          last          <= 1'b0;
        end
      end

      if (state == ST_FINISH) begin
        result_valid  <= 1'b1;
        pair_valid    <= held_vld;
        earlier_index <= held_vld ? IDX_W'(held_idx) : '0;
        new_index     <= IDX_W'(pos);
        table_full    <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

  a_full_reply: assert property (@(posedge clk) disable iff (rst)
    accept && !is_clear && is_full |=> result_valid && table_full && last)
    else $error("full-table add did not give a flagged result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count beyond table depth");

  a_nopair_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !pair_valid |-> last)
    else $error("result without pair not marked last");

  a_finish_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> result_valid && last && !busy)
    else $error("scan ended without final result");

endmodule
